// ----- design/cpu_bus_memory_map_defines.svh -----
// ----------------------------------------------------------------------------
// cpu bus memory map assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CPU_BUS_MEMORY_MAP_DEFINES_SVH
`define CPU_BUS_MEMORY_MAP_DEFINES_SVH

// same-cycle implication, held off during reset
`define CBMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbmm port check failed");

// next-cycle implication, held off during reset
`define CBMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbmm port check failed");

`endif

// ----- design/cbmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbmm_pkg
// widths, address constants and controller/datapath types
// ----------------------------------------------------------------------------
package cbmm_pkg;

    // stream word layouts
    localparam int IN_DATA_W  = 40;   // bank, offset_in_bank, write_value
    localparam int IN_USER_W  = 2;    // operation, word_size
    localparam int OUT_DATA_W = 168;  // target, read_value, cpu est, audio est
    localparam int OUT_USER_W = 4;    // region, covers_word, audio_port
    localparam int CFG_W      = 16;

    // work ram
    localparam int WORK_RAM_BYTES = 131072;
    localparam int WRAM_AW        = 17;
    localparam int WRAM_HALF_AW   = 16;
    localparam int WRAM_HALF_BYTES = WORK_RAM_BYTES / 2;
    localparam logic [WRAM_AW-1:0] WRAM_LAST_IDX = WRAM_AW'(WORK_RAM_BYTES - 1);

    // battery ram offset before reduction, and remainder step count
    localparam int OFF_W     = 19;
    localparam int DIV_CNT_W = 5;

    // address decode constants
    localparam logic [7:0]  BANK_WRAM_LO  = 8'h7e;
    localparam logic [7:0]  BANK_WRAM_HI  = 8'h7f;
    localparam logic [7:0]  BANK_LOW_END  = 8'h3f;
    localparam logic [7:0]  BANK_SRAM_A_LO = 8'h70;
    localparam logic [7:0]  BANK_SRAM_A_HI = 8'h7d;
    localparam logic [7:0]  BANK_SRAM_B_LO = 8'hf0;
    localparam logic [7:0]  BANK_SRAM_B_HI = 8'hfd;
    localparam logic [15:0] ADDR_HW_LO    = 16'h2000;
    localparam logic [15:0] ADDR_SRAM_LO  = 16'h6000;
    localparam logic [15:0] ADDR_ROM_LO   = 16'h8000;
    localparam logic [15:0] ADDR_APU_LO   = 16'h2140;
    localparam logic [15:0] ADDR_APU_HI   = 16'h217f;
    localparam logic [15:0] ADDR_LAST     = 16'hffff;

    localparam logic [63:0] PACE_STEP = 64'd256;

    typedef enum logic [1:0] {
        RGN_WRAM = 2'd0,
        RGN_HW   = 2'd1,
        RGN_SRAM = 2'd2,
        RGN_ROM  = 2'd3
    } t_region;

    typedef struct packed {
        logic load;      // latch a new access
        logic access;    // decode piece, work ram op or remainder start
        logic div_step;  // one remainder step
        logic sram_go;   // battery ram op
        logic emit;      // load the output word
    } t_cmd;

    typedef struct packed {
        logic is_sram;
        logic div_done;
        logic out_free;
        logic last;
    } t_status;

endpackage

// ----- design/cpu_bus_memory_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_bus_memory_map
// cartridge memory map decoder for one cpu bus access per input word
// ----------------------------------------------------------------------------
// Each input word is one cpu bus access (read or write, byte or little-endian
// word) and yields one or two output words, the final one flagged by tlast.
// Work ram (banks 7e/7f and the low 8 kb mirror) and battery ram live inside
// the block; hardware registers and rom are only decoded and reported. A
// word access is one output word in work ram (unless it starts at the very
// last byte) and at a register; everywhere else it splits into two byte
// words, the second at offset+1 with the bank carried at ffff. Timing is set
// by a fixed sequence of controller states, one access at a time, with an
// access and an emit state for each output word. Battery ram offsets are
// reduced modulo the configured size by a one-bit-per-cycle remainder unit
// before each battery ram byte. A finished word sits in the output register,
// so a stalled master side holds the block only when the next word is ready.
// The save_ram_size register is written with i_cfg_we; the user must write
// it only while no access is in flight, which the block does not enforce.
// Sizes above SAVE_RAM_BYTES count as SAVE_RAM_BYTES, zero means no battery
// ram. Neither ram is cleared after reset.
// ----------------------------------------------------------------------------
module cpu_bus_memory_map #(
    parameter int SAVE_RAM_BYTES = 32768
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: save_ram_size
    input  logic                            i_cfg_we,
    input  logic [cbmm_pkg::CFG_W-1:0]      i_cfg_wdata,
    // access stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // bank[7:0], offset_in_bank[23:8], write_value[39:24]
    input  logic [cbmm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation[0], word_size[1]
    input  logic [cbmm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // target[23:0], read_value[39:24], cpu_cycle_estimate[103:40],
    // audio_cycle_estimate[167:104]
    output logic [cbmm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // region[1:0], covers_word[2], audio_port[3]
    output logic [cbmm_pkg::OUT_USER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);
    import cbmm_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    cbmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // decode, memories, remainder unit, estimates and output register
    cbmm_datapath #(
        .SAVE_RAM_BYTES (SAVE_RAM_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// ----- design/cbmm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbmm_ctrl
// sequencer for one access: decode, optional remainder, memory, emit
// ----------------------------------------------------------------------------
module cbmm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cbmm_pkg::t_status i_status,
    output cbmm_pkg::t_cmd    o_cmd
);
    import cbmm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_DIV,
        S_SACC,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   accept;

    assign accept     = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && accept;
        o_cmd.access   = (r_state == S_ACCESS);
        o_cmd.div_step = (r_state == S_DIV) && !i_status.div_done;
        o_cmd.sram_go  = (r_state == S_SACC);
        o_cmd.emit     = (r_state == S_EMIT) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_ACCESS;
            end
            S_ACCESS: begin
                n_state = i_status.is_sram ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                if (i_status.div_done) n_state = S_SACC;
            end
            S_SACC: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) n_state = i_status.last ? S_IDLE : S_ACCESS;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

// ----- design/cbmm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbmm_datapath
// address decode, work and battery ram, serial remainder, estimates, output
// ----------------------------------------------------------------------------
module cbmm_datapath #(
    parameter int SAVE_RAM_BYTES = 32768
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cbmm_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic [cbmm_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic [cbmm_pkg::IN_USER_W-1:0]    i_in_user,
    input  cbmm_pkg::t_cmd                    i_cmd,
    output cbmm_pkg::t_status                 o_status,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [cbmm_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic [cbmm_pkg::OUT_USER_W-1:0]   o_out_user,
    output logic                              o_out_last
);
    import cbmm_pkg::*;

    localparam int SRAM_AW = $clog2(SAVE_RAM_BYTES);
    localparam logic [19:0] SAVE_CAP = 20'(SAVE_RAM_BYTES);

    // configuration
    logic [CFG_W-1:0] r_size;
    logic [15:0]      size_eff;

    // current piece
    logic        r_op;
    logic        r_word;
    logic        r_second;
    logic [7:0]  r_bank;
    logic [15:0] r_addr;
    logic [15:0] r_wdata;

    // memories
    logic [7:0] r_wram_even [0:WRAM_HALF_BYTES-1];
    logic [7:0] r_wram_odd  [0:WRAM_HALF_BYTES-1];
    logic [7:0] r_sram      [0:SAVE_RAM_BYTES-1];
    logic [7:0] r_even_rd;
    logic [7:0] r_odd_rd;
    logic [7:0] r_sram_rd;

    // remainder unit
    logic [OFF_W-1:0]     r_dividend;
    logic [15:0]          r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [16:0]          trial;
    logic [16:0]          divisor;
    logic                 div_done;

    // estimates and output
    logic [63:0]           r_cpu;
    logic [63:0]           r_aud;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic                  r_out_last;

    // decode
    logic               low_half;
    logic               wram_hit;
    logic [WRAM_AW-1:0] wram_idx;
    logic               hw_hit;
    logic               sram_big;
    logic               sram_small;
    logic               sram_hit;
    logic [OFF_W-1:0]   sram_off;
    t_region            region;
    logic               audio;
    logic               combined;
    logic               last;

    logic [WRAM_HALF_AW-1:0] half;
    logic                    lo_is_odd;
    logic [WRAM_HALF_AW-1:0] even_addr;
    logic                    wram_op;
    logic                    even_we;
    logic                    odd_we;
    logic [7:0]              even_wd;
    logic [7:0]              odd_wd;
    logic [15:0]             wram_rd_val;
    logic [23:0]             rem24;
    logic [SRAM_AW-1:0]      sram_addr;

    logic        pace;
    logic        ap;
    logic [63:0] n_cpu;
    logic [63:0] n_aud;
    logic [23:0] target;
    logic [15:0] rd_val;

    assign size_eff = ({4'b0, r_size} > SAVE_CAP) ? SAVE_CAP[15:0] : r_size;

    always_comb begin
        low_half = (r_bank <= BANK_LOW_END) || (r_bank[7:6] == 2'b10);

        wram_hit = 1'b1;
        wram_idx = {1'b0, r_addr};
        if (r_bank == BANK_WRAM_HI) begin
            wram_idx = {1'b1, r_addr};
        end else if (!(r_bank == BANK_WRAM_LO || (r_addr < ADDR_HW_LO && low_half))) begin
            wram_hit = 1'b0;
        end

        hw_hit = (r_addr >= ADDR_HW_LO) && (r_addr < ADDR_SRAM_LO) && low_half;

        sram_big = ((r_bank >= BANK_SRAM_A_LO && r_bank <= BANK_SRAM_A_HI) ||
                    (r_bank >= BANK_SRAM_B_LO && r_bank <= BANK_SRAM_B_HI)) &&
                   (r_addr < ADDR_ROM_LO);
        sram_small = low_half && (r_addr >= ADDR_SRAM_LO) && (r_addr < ADDR_ROM_LO);
        sram_off = sram_big ? {r_bank[3:0], r_addr[14:0]} : {1'b0, r_bank[4:0], r_addr[12:0]};
        sram_hit = (size_eff != 16'd0) && (sram_big || sram_small);

        if (wram_hit)      region = RGN_WRAM;
        else if (hw_hit)   region = RGN_HW;
        else if (sram_hit) region = RGN_SRAM;
        else               region = RGN_ROM;

        audio    = (r_addr >= ADDR_APU_LO) && (r_addr <= ADDR_APU_HI);
        combined = r_word && !r_second &&
                   ((wram_hit && (wram_idx != WRAM_LAST_IDX)) || hw_hit);
        last     = !r_word || r_second || combined;
    end

    // work ram split into even and odd byte lanes so a word is one access
    assign half      = wram_idx[WRAM_AW-1:1];
    assign lo_is_odd = wram_idx[0];
    assign even_addr = lo_is_odd ? half + 1'b1 : half;
    assign wram_op   = i_cmd.access && (region == RGN_WRAM);
    assign even_we   = wram_op && r_op && (!lo_is_odd || combined);
    assign odd_we    = wram_op && r_op && (lo_is_odd || combined);
    assign even_wd   = lo_is_odd ? r_wdata[15:8] : r_wdata[7:0];
    assign odd_wd    = lo_is_odd ? r_wdata[7:0] : r_wdata[15:8];

    always_ff @(posedge i_clk) begin
        if (even_we) r_wram_even[even_addr] <= even_wd;
        if (wram_op && !r_op) r_even_rd <= r_wram_even[even_addr];
    end

    always_ff @(posedge i_clk) begin
        if (odd_we) r_wram_odd[half] <= odd_wd;
        if (wram_op && !r_op) r_odd_rd <= r_wram_odd[half];
    end

    always_comb begin
        if (combined) wram_rd_val = lo_is_odd ? {r_even_rd, r_odd_rd} : {r_odd_rd, r_even_rd};
        else          wram_rd_val = {8'b0, (lo_is_odd ? r_odd_rd : r_even_rd)};
    end

    // battery ram, addressed by the reduced offset
    assign rem24     = {8'b0, r_rem};
    assign sram_addr = rem24[SRAM_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.sram_go && r_op) r_sram[sram_addr] <= r_wdata[7:0];
        if (i_cmd.sram_go && !r_op) r_sram_rd <= r_sram[sram_addr];
    end

    // restoring remainder, one dividend bit a step
    assign divisor  = {1'b0, size_eff};
    assign trial    = {r_rem, r_dividend[OFF_W-1]};
    assign div_done = (r_div_cnt == DIV_CNT_W'(OFF_W));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.access) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.access) begin
            r_dividend <= sram_off;
            r_rem      <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[OFF_W-2:0], 1'b0};
            r_rem      <= (trial >= divisor) ? 16'(trial - divisor) : trial[15:0];
        end
    end

    // output word
    always_comb begin
        pace  = (region == RGN_HW);
        ap    = pace && audio;
        n_cpu = r_cpu + (pace ? PACE_STEP : 64'd0);
        n_aud = r_aud + (ap ? PACE_STEP : 64'd0);
        case (region)
            RGN_WRAM: target = {7'b0, wram_idx};
            RGN_HW:   target = {8'b0, r_addr};
            RGN_SRAM: target = rem24;
            RGN_ROM:  target = {r_bank, r_addr};
            default:  target = {r_bank, r_addr};
        endcase
        rd_val = 16'd0;
        if (!r_op && region == RGN_WRAM) rd_val = wram_rd_val;
        if (!r_op && region == RGN_SRAM) rd_val = {8'b0, r_sram_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= '0;
            r_cpu       <= '0;
            r_aud       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_size <= i_cfg_wdata;
            if (i_cmd.emit) begin
                r_cpu       <= n_cpu;
                r_aud       <= n_aud;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {n_aud, n_cpu, rd_val, target};
            r_out_user <= {ap, combined, region};
            r_out_last <= last;
        end
    end

    // piece registers: new access, or step to the second byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in_user[0];
            r_word   <= i_in_user[1];
            r_second <= 1'b0;
            r_bank   <= i_in_data[7:0];
            r_addr   <= i_in_data[23:8];
            r_wdata  <= i_in_data[39:24];
        end else if (i_cmd.emit && !last) begin
            r_second <= 1'b1;
            r_bank   <= r_bank + {7'b0, (r_addr == ADDR_LAST)};
            r_addr   <= r_addr + 1'b1;
            r_wdata  <= {8'b0, r_wdata[15:8]};
        end
    end

    assign o_status.is_sram  = (region == RGN_SRAM);
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.last     = last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

endmodule

// ----- design/cbmm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbmm_checker
// port-level checks on the result stream of the memory map decoder
// ----------------------------------------------------------------------------
`include "cpu_bus_memory_map_defines.svh"

module cbmm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [cbmm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [cbmm_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input logic                            m_axis_tlast
);
    import cbmm_pkg::*;

    logic [1:0] out_region;
    logic       out_word;
    logic       out_audio;
    logic       out_ext;
    logic       word_rgn_ok;
    logic       out_stall;

    assign out_region  = m_axis_tuser[1:0];
    assign out_word    = m_axis_tvalid && m_axis_tuser[2];
    assign out_audio   = m_axis_tvalid && m_axis_tuser[3];
    assign out_ext     = m_axis_tvalid && (out_region == RGN_HW || out_region == RGN_ROM);
    assign word_rgn_ok = (out_region == RGN_WRAM) || (out_region == RGN_HW);
    assign out_stall   = m_axis_tvalid && !m_axis_tready;

    // a word carried whole is always the whole access
    `CBMM_ASSERT_IMP(a_word_is_last, i_clk, i_rst_n, out_word, m_axis_tlast)

    // only work ram and registers carry a word in one piece
    `CBMM_ASSERT_IMP(a_word_region, i_clk, i_rst_n, out_word, word_rgn_ok)

    // audio pacing only from register accesses
    `CBMM_ASSERT_IMP(a_audio_region, i_clk, i_rst_n, out_audio, out_region == RGN_HW)

    // external regions never return read data
    `CBMM_ASSERT_IMP(a_ext_no_data, i_clk, i_rst_n, out_ext, m_axis_tdata[39:24] == 16'd0)

    // stalled result holds
    `CBMM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind cpu_bus_memory_map cbmm_checker u_cbmm_checker (.*);

// ----- dv/cpu_bus_memory_map_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_bus_memory_map_test
// self-checking bench for the cartridge memory map decoder
// ----------------------------------------------------------------------------
// Access words are queued by the stimulus process and sent by a clocked
// driver with random gaps. Every accepted access runs through a local
// predictor (its own copy of work ram, battery ram, the two pacing estimates
// and the battery ram size), which queues the result words it expects. A
// clocked monitor pulls result words with random stalls and compares each
// against the oldest expected word. The run steps through several battery
// ram sizes, written only while the block is quiet. Reads are only sent to
// bytes that an earlier write has filled.
// ----------------------------------------------------------------------------
module cpu_bus_memory_map_test;
    import cbmm_pkg::*;

    localparam int          SAVE_BYTES       = 32768;
    localparam int          HALF_PERIOD      = 6;
    localparam int          RANDOM_PER_PHASE = 50;
    localparam int          HOLD_CYCLES      = 300;
    localparam int          TAIL_CYCLES      = 60;
    localparam int          STALL_LIMIT      = 3000;
    localparam int          REPORT_LIMIT     = 10;
    localparam int          SPOT_DEPTH       = 64;
    localparam logic [7:0]  BANK_HIGH_LO     = 8'h80;
    localparam logic [7:0]  BANK_HIGH_END    = 8'hbf;
    localparam bit          OP_READ          = 1'b0;
    localparam bit          OP_WRITE         = 1'b1;
    localparam bit          SIZE_BYTE        = 1'b0;
    localparam bit          SIZE_WORD        = 1'b1;
    // battery ram sizes visited in order, zero and both ends among them
    localparam logic [15:0] SIZE_PLAN [8] = '{16'd32768, 16'd1, 16'd65535, 16'd12345,
                                              16'd0, 16'd2048, 16'd3, 16'd40000};

    // one cpu bus access as sent
    typedef struct packed {
        logic        op;
        logic        word;
        logic [7:0]  bank;
        logic [15:0] addr;
        logic [15:0] wval;
    } t_access;

    // where one byte of an access lands
    typedef struct packed {
        t_region     rgn;
        logic [23:0] target;
    } t_place;

    // one result word, holding the fields named in the port comments
    typedef struct packed {
        t_region     region;
        logic [23:0] target;
        logic        covers_word;
        logic [15:0] read_value;
        logic        audio_port;
        logic [63:0] cpu_est;
        logic [63:0] apu_est;
        logic        is_last;
    } t_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    // predictor state
    logic [7:0]  wram_img [0:WORK_RAM_BYTES-1];
    logic [7:0]  sram_img [0:SAVE_BYTES-1];
    logic [63:0] cpu_est = '0;
    logic [63:0] apu_est = '0;
    logic [15:0] save_size_cfg = '0;

    // stimulus bookkeeping: which stored bytes have been filled
    bit          wram_filled [0:WORK_RAM_BYTES-1];
    bit          sram_filled [0:SAVE_BYTES-1];
    t_access     written_spots [$];

    t_access     pending_accesses [$];
    t_result     expected_results [$];
    t_access     on_offer;

    int          src_idle_pct  = 22;
    int          sink_idle_pct = 22;
    bit          hold_request  = 1'b0;
    int          hold_left     = 0;
    int          err_count     = 0;
    int          stall_cycles  = 0;

    cpu_bus_memory_map #(
        .SAVE_RAM_BYTES (SAVE_BYTES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    // decode one byte address: work ram first, then registers, battery ram, rom
    function automatic t_place locate(input logic [7:0] bank, input logic [15:0] addr,
                                      input logic [15:0] size_reg);
        t_place      p;
        logic        low;
        logic [18:0] off;
        int unsigned span;
        low  = (bank <= BANK_LOW_END) || (bank >= BANK_HIGH_LO && bank <= BANK_HIGH_END);
        span = (size_reg > SAVE_BYTES) ? SAVE_BYTES : size_reg;
        p.rgn    = RGN_ROM;
        p.target = {bank, addr};
        if (bank == BANK_WRAM_LO) begin
            p.rgn    = RGN_WRAM;
            p.target = {8'h00, addr};
        end else if (bank == BANK_WRAM_HI) begin
            p.rgn    = RGN_WRAM;
            p.target = {8'h01, addr};
        end else if (low && addr < ADDR_HW_LO) begin
            // low 8 kb mirror of work ram
            p.rgn    = RGN_WRAM;
            p.target = {8'h00, addr};
        end else if (low && addr < ADDR_SRAM_LO) begin
            p.rgn    = RGN_HW;
            p.target = {8'h00, addr};
        end else if (span != 0) begin
            if (((bank >= BANK_SRAM_A_LO && bank <= BANK_SRAM_A_HI) ||
                 (bank >= BANK_SRAM_B_LO && bank <= BANK_SRAM_B_HI)) && addr < ADDR_ROM_LO) begin
                off      = {bank[3:0], addr[14:0]};
                p.rgn    = RGN_SRAM;
                p.target = 24'(off % span);
            end else if (low && addr >= ADDR_SRAM_LO && addr < ADDR_ROM_LO) begin
                // 8 kb window at 6000 per bank, in-bank offset is addr - 6000
                off      = {1'b0, bank[4:0], addr[12:0]};
                p.rgn    = RGN_SRAM;
                p.target = 24'(off % span);
            end
        end
        return p;
    endfunction

    // word that is carried in one result: work ram not at its last byte, or a register
    function automatic bit whole_word(input t_access a, input t_place p);
        return (a.word == SIZE_WORD) &&
               ((p.rgn == RGN_WRAM && p.target[WRAM_AW-1:0] != WRAM_LAST_IDX) ||
                p.rgn == RGN_HW);
    endfunction

    function automatic logic pace(input logic [15:0] addr);
        cpu_est += PACE_STEP;
        if (addr >= ADDR_APU_LO && addr <= ADDR_APU_HI) begin
            apu_est += PACE_STEP;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one byte piece; covers_word and is_last are left at zero
    function automatic t_result byte_piece(input logic op, input logic [7:0] bank,
                                           input logic [15:0] addr, input logic [7:0] val);
        t_place  p;
        t_result r;
        p        = locate(bank, addr, save_size_cfg);
        r        = '0;
        r.region = p.rgn;
        r.target = p.target;
        case (p.rgn)
            RGN_WRAM: begin
                if (op == OP_WRITE) wram_img[p.target[WRAM_AW-1:0]] = val;
                else r.read_value = {8'h00, wram_img[p.target[WRAM_AW-1:0]]};
            end
            RGN_HW: begin
                r.audio_port = pace(addr);
            end
            RGN_SRAM: begin
                if (op == OP_WRITE) sram_img[p.target[14:0]] = val;
                else r.read_value = {8'h00, sram_img[p.target[14:0]]};
            end
            default: ;
        endcase
        r.cpu_est = cpu_est;
        r.apu_est = apu_est;
        return r;
    endfunction

    // expected result words for one accepted access
    task automatic predict_access(input t_access a);
        t_place          p;
        t_result         r;
        logic [WRAM_AW-1:0] idx;
        logic [7:0]      bank2;
        logic [15:0]     addr2;
        p = locate(a.bank, a.addr, save_size_cfg);
        if (whole_word(a, p)) begin
            r             = '0;
            r.region      = p.rgn;
            r.target      = p.target;
            r.covers_word = 1'b1;
            r.is_last     = 1'b1;
            idx           = p.target[WRAM_AW-1:0];
            if (p.rgn == RGN_HW) begin
                r.audio_port = pace(a.addr);
            end else if (a.op == OP_WRITE) begin
                wram_img[idx]         = a.wval[7:0];
                wram_img[idx + 1'b1]  = a.wval[15:8];
            end else begin
                r.read_value = {wram_img[idx + 1'b1], wram_img[idx]};
            end
            r.cpu_est = cpu_est;
            r.apu_est = apu_est;
            expected_results.push_back(r);
        end else if (a.word == SIZE_BYTE) begin
            r         = byte_piece(a.op, a.bank, a.addr, a.wval[7:0]);
            r.is_last = 1'b1;
            expected_results.push_back(r);
        end else begin
            // split word: second byte at offset+1, bank carries out of ffff
            bank2 = a.bank + 8'(a.addr == ADDR_LAST);
            addr2 = a.addr + 16'd1;
            r     = byte_piece(a.op, a.bank, a.addr, a.wval[7:0]);
            expected_results.push_back(r);
            r         = byte_piece(a.op, bank2, addr2, a.wval[15:8]);
            r.is_last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    function automatic bit is_filled(input t_place p);
        if (p.rgn == RGN_WRAM) return wram_filled[p.target[WRAM_AW-1:0]];
        if (p.rgn == RGN_SRAM) return sram_filled[p.target[14:0]];
        return 1'b1;
    endfunction

    function automatic void mark_filled(input t_place p);
        if (p.rgn == RGN_WRAM) wram_filled[p.target[WRAM_AW-1:0]] = 1'b1;
        if (p.rgn == RGN_SRAM) sram_filled[p.target[14:0]] = 1'b1;
    endfunction

    // queue one access; a read that would touch an unfilled byte becomes a write
    task automatic queue_access(input logic op, input logic word, input logic [7:0] bank,
                                input logic [15:0] addr, input logic [15:0] wval);
        t_access a;
        t_place  p0;
        t_place  p1;
        a  = '{op: op, word: word, bank: bank, addr: addr, wval: wval};
        p0 = locate(bank, addr, save_size_cfg);
        p1 = p0;
        if (whole_word(a, p0) && p0.rgn == RGN_WRAM) begin
            p1.target = p0.target + 24'd1;
        end else if (word == SIZE_WORD && !whole_word(a, p0)) begin
            p1 = locate(bank + 8'(addr == ADDR_LAST), addr + 16'd1, save_size_cfg);
        end
        if (a.op == OP_READ && !(is_filled(p0) && is_filled(p1))) a.op = OP_WRITE;
        if (a.op == OP_WRITE) begin
            mark_filled(p0);
            mark_filled(p1);
            written_spots.push_back(a);
            if (written_spots.size() > SPOT_DEPTH) void'(written_spots.pop_front());
        end
        pending_accesses.push_back(a);
    endtask

    function automatic logic [7:0] low_bank();
        return $urandom_range(1) ? 8'($urandom_range(BANK_LOW_END))
                                 : 8'($urandom_range(BANK_HIGH_END, BANK_HIGH_LO));
    endfunction

    // random access biased toward each region, with edge offsets and re-reads
    function automatic t_access random_access();
        t_access     a;
        t_access     reuse;
        int unsigned pick;
        a.op   = 1'($urandom_range(1));
        a.word = 1'($urandom_range(1));
        a.bank = 8'($urandom_range(255));
        a.addr = 16'($urandom_range(16'hffff));
        a.wval = 16'($urandom_range(16'hffff));
        pick   = $urandom_range(99);
        if (pick < 25) begin
            case ($urandom_range(2))
                0: a.bank = BANK_WRAM_LO;
                1: a.bank = BANK_WRAM_HI;
                default: begin
                    a.bank = low_bank();
                    a.addr = 16'($urandom_range(ADDR_HW_LO - 1));
                end
            endcase
        end else if (pick < 45) begin
            a.bank = low_bank();
            a.addr = $urandom_range(1) ? 16'($urandom_range(ADDR_APU_HI, ADDR_APU_LO))
                                       : 16'($urandom_range(ADDR_SRAM_LO - 1, ADDR_HW_LO));
        end else if (pick < 70) begin
            if ($urandom_range(1)) begin
                a.bank = $urandom_range(1) ? 8'($urandom_range(BANK_SRAM_A_HI, BANK_SRAM_A_LO))
                                           : 8'($urandom_range(BANK_SRAM_B_HI, BANK_SRAM_B_LO));
                a.addr = 16'($urandom_range(ADDR_ROM_LO - 1));
            end else begin
                a.bank = low_bank();
                a.addr = 16'($urandom_range(ADDR_ROM_LO - 1, ADDR_SRAM_LO));
            end
        end else if (pick < 82) begin
            // region boundaries and the bank carry
            case ($urandom_range(7))
                0: a.addr = ADDR_LAST;
                1: a.addr = 16'h0000;
                2: a.addr = ADDR_HW_LO - 1;
                3: a.addr = ADDR_HW_LO;
                4: a.addr = ADDR_SRAM_LO - 1;
                5: a.addr = ADDR_SRAM_LO;
                6: a.addr = ADDR_ROM_LO - 1;
                default: a.addr = ADDR_ROM_LO;
            endcase
        end
        // reads mostly go back to places written earlier
        if (a.op == OP_READ && written_spots.size() != 0 && $urandom_range(99) < 60) begin
            reuse  = written_spots[$urandom_range(written_spots.size() - 1)];
            a.bank = reuse.bank;
            a.addr = reuse.addr;
        end
        return a;
    endfunction

    // register writes only while the block is quiet
    task automatic write_save_size(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        save_size_cfg = v;
        @(negedge i_clk);
    endtask

    // wait until every queued access is sent and every expected word is back
    task automatic settle();
        do @(negedge i_clk);
        while (pending_accesses.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // access driver: predicts on acceptance, then offers the next queued word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_access(on_offer);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    on_offer = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {on_offer.wval, on_offer.addr, on_offer.bank};
                    s_axis_tuser  <= {on_offer.word, on_offer.op};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: checks each word taken, drives tready with stalls and the long hold
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.region      = t_region'(m_axis_tuser[1:0]);
                got.covers_word = m_axis_tuser[2];
                got.audio_port  = m_axis_tuser[3];
                got.target      = m_axis_tdata[23:0];
                got.read_value  = m_axis_tdata[39:24];
                got.cpu_est     = m_axis_tdata[103:40];
                got.apu_est     = m_axis_tdata[167:104];
                got.is_last     = m_axis_tlast;
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("unexpected result word: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= REPORT_LIMIT)
                            $display("result mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            // the hold is counted here so the sender keeps offering meanwhile
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("cpu_bus_memory_map_test: errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_access a;
        int      k;
        int      n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no battery ram after reset: work ram ends, registers, rom, bank carry
        queue_access(OP_WRITE, SIZE_BYTE, BANK_WRAM_LO, 16'h0000, 16'h00ff);
        queue_access(OP_WRITE, SIZE_WORD, BANK_WRAM_HI, 16'hfffe, 16'ha55a);
        // last work ram byte: splits, second byte lands in the mirror at 80:0000
        queue_access(OP_WRITE, SIZE_WORD, BANK_WRAM_HI, ADDR_LAST, 16'h1234);
        // 7e:ffff runs on into 7f:0000 in one piece
        queue_access(OP_WRITE, SIZE_WORD, BANK_WRAM_LO, ADDR_LAST, 16'hbeef);
        queue_access(OP_READ,  SIZE_WORD, BANK_WRAM_LO, ADDR_LAST, 16'h0000);
        queue_access(OP_READ,  SIZE_WORD, BANK_WRAM_HI, ADDR_LAST, 16'h0000);
        queue_access(OP_READ,  SIZE_BYTE, BANK_WRAM_HI, 16'hfffe, 16'h0000);
        queue_access(OP_WRITE, SIZE_WORD, 8'h00, 16'h1fff, 16'hffff);
        queue_access(OP_READ,  SIZE_WORD, BANK_LOW_END, 16'h1fff, 16'h0000);
        queue_access(OP_READ,  SIZE_WORD, 8'h00, ADDR_APU_LO, 16'h0000);
        queue_access(OP_WRITE, SIZE_BYTE, 8'h00, ADDR_APU_LO - 1, 16'h0077);
        queue_access(OP_READ,  SIZE_WORD, BANK_HIGH_END, ADDR_APU_HI, 16'h0000);
        queue_access(OP_WRITE, SIZE_BYTE, BANK_HIGH_LO, ADDR_APU_HI + 1, 16'h1100);
        queue_access(OP_READ,  SIZE_WORD, BANK_LOW_END, ADDR_SRAM_LO - 1, 16'h0000);
        queue_access(OP_WRITE, SIZE_BYTE, BANK_SRAM_A_LO, 16'h0000, 16'h0055);
        // rom word at ff:ffff wraps the bank to 00:0000 in work ram
        queue_access(OP_READ,  SIZE_WORD, 8'hff, ADDR_LAST, 16'h0000);
        queue_access(OP_WRITE, SIZE_BYTE, 8'h40, ADDR_ROM_LO, 16'h0000);
        queue_access(OP_READ,  SIZE_WORD, 8'h00, ADDR_LAST, 16'h0000);
        for (n = 0; n < RANDOM_PER_PHASE - 5; n++) begin
            a = random_access();
            queue_access(a.op, a.word, a.bank, a.addr, a.wval);
        end
        settle();

        for (k = 0; k < $size(SIZE_PLAN); k++) begin
            write_save_size(SIZE_PLAN[k]);
            if (k == 0) begin
                // full battery ram: both windows, top offsets, splits into rom
                queue_access(OP_WRITE, SIZE_WORD, BANK_SRAM_A_LO, 16'h0000, 16'h0102);
                queue_access(OP_WRITE, SIZE_BYTE, BANK_SRAM_B_HI, ADDR_ROM_LO - 1, 16'h0080);
                queue_access(OP_WRITE, SIZE_WORD, BANK_SRAM_A_HI, ADDR_ROM_LO - 1, 16'hc3d4);
                queue_access(OP_WRITE, SIZE_WORD, BANK_LOW_END, ADDR_ROM_LO - 1, 16'h5a5a);
                queue_access(OP_READ,  SIZE_WORD, BANK_SRAM_A_LO, 16'h0000, 16'h0000);
                queue_access(OP_READ,  SIZE_BYTE, BANK_SRAM_B_LO, 16'h0001, 16'h0000);
                queue_access(OP_READ,  SIZE_WORD, BANK_LOW_END, ADDR_ROM_LO - 1, 16'h0000);
                queue_access(OP_READ,  SIZE_BYTE, 8'h20, ADDR_SRAM_LO, 16'h0000);
            end
            // one phase runs without any idling on either side
            src_idle_pct  = (k == 3) ? 0 : 22;
            sink_idle_pct = (k == 3) ? 0 : 22;
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                a = random_access();
                queue_access(a.op, a.word, a.bank, a.addr, a.wval);
            end
            // long receiver hold so the block backs up into its input
            if (k == 1) hold_request = 1'b1;
            settle();
        end

        if (err_count == 0)
            $display("cpu_bus_memory_map_test: clean");
        else
            $display("cpu_bus_memory_map_test: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/cbmm_pkg.sv
design/cbmm_ctrl.sv
design/cbmm_datapath.sv
design/cpu_bus_memory_map.sv
design/cbmm_checker.sv
dv/cpu_bus_memory_map_test.sv
